>>> design/psd_pkg.sv
// Package for the point to segment distance block.
// Holds word types, configuration layout, widths and register indexes.
// No dependencies.
package psd_pkg;

   localparam int SumW     = 66;  // widest squared distance, scaled
   localparam int ScaleW   = 32;  // a*a + b*b fits in 32 unsigned bits
   localparam int RootBits = 16;  // result bits, one per root stage
   localparam int QsW      = 48;  // q * scale
   localparam int CsrAddrW = 5;   // five registers at 4-byte spacing

   typedef enum logic [2:0] {
      CSR_COEF_A     = 3'd0,
      CSR_COEF_B     = 3'd1,
      CSR_COEF_C     = 3'd2,
      CSR_SEG_X_LOW  = 3'd3,
      CSR_SEG_X_HIGH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } req_type;

   typedef struct packed {
      logic [15:0] dist_res;
      logic        invalid;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [15:0] seg_x_low;
      logic signed [15:0] seg_x_high;
   } cfg_type;

   // hand-off from geometry stages to the root pipeline
   typedef struct packed {
      logic [SumW-1:0]   sq;
      logic [ScaleW-1:0] scale;
      logic              invalid;
   } geo_type;

endpackage

>>> design/point_segment_distance_top.sv
// Top level of the point to segment distance block: register file,
// geometry stages and root pipeline. Depends on psd_pkg, psd_geom, psd_root.
//
// Use:
//   Input words (point_x, point_y) enter on req_word. A word is taken at a
//   clock edge with start high and busy low. busy is low at all times except
//   during reset, so one point can be taken every cycle.
//   Each point gives exactly one result word on rsp_word, shown for a single
//   cycle with rsp_strobe high. The receiver has no way to hold it off.
//   A point passes the input register, four geometry stages and sixteen
//   root stages before its result is shown on rsp_word.
//   Throughput: one word per cycle, set by the root pipeline, which resolves
//   one result bit per stage.
//   Line and segment bounds sit in an APB register file (coef_a at 0x00,
//   coef_b 0x04, coef_c 0x08, seg_x_low 0x0C, seg_x_high 0x10). Write them
//   only with no point in flight; writes elsewhere are dropped.
//   Reset (synchronous) drops every point in flight and loads the line
//   0*x + 1*y + 0 = 0 with both bounds at 0.
//   A line with a = b = 0 gives invalid = 1 and a distance of 0.
module point_segment_distance_top
   import psd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // point channel
   input  logic                start,
   output logic                busy,
   input  req_type             req_word,
   // result channel
   output logic                rsp_strobe,
   output rsp_type             rsp_word,
   // register file
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;
   logic    take;
   logic    geo_valid;
   geo_type geo;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // register writes, sign is kept in the stored word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (paddr[CsrAddrW-1:2])
            CSR_COEF_A:     cfg_in.coef_a     = pwdata[15:0];
            CSR_COEF_B:     cfg_in.coef_b     = pwdata[15:0];
            CSR_COEF_C:     cfg_in.coef_c     = pwdata;
            CSR_SEG_X_LOW:  cfg_in.seg_x_low  = pwdata[15:0];
            CSR_SEG_X_HIGH: cfg_in.seg_x_high = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a     <= 16'sd0;
         cfg_ff.coef_b     <= 16'sd1;
         cfg_ff.coef_c     <= 32'sd0;
         cfg_ff.seg_x_low  <= 16'sd0;
         cfg_ff.seg_x_high <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, sign extended to the bus
   always_comb begin
      case (paddr[CsrAddrW-1:2])
         CSR_COEF_A:     prdata = 32'(cfg_ff.coef_a);
         CSR_COEF_B:     prdata = 32'(cfg_ff.coef_b);
         CSR_COEF_C:     prdata = cfg_ff.coef_c;
         CSR_SEG_X_LOW:  prdata = 32'(cfg_ff.seg_x_low);
         CSR_SEG_X_HIGH: prdata = 32'(cfg_ff.seg_x_high);
         default:        prdata = '0;
      endcase
   end

   // pipeline never stalls; only reset holds off new points
   assign busy = reset;
   assign take = start && !busy;

   psd_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_word   (req_word),
      .cfg       (cfg_ff),
      .out_valid (geo_valid),
      .out_geo   (geo)
   );

   psd_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geo_valid),
      .in_geo    (geo),
      .out_valid (rsp_strobe),
      .out_word  (rsp_word)
   );

endmodule

>>> design/psd_geom.sv
// Geometry front end: input register plus four stages that form the
// projection test and the scaled squared distance. Depends on psd_pkg.
module psd_geom
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_word,
   input  cfg_type cfg,
   output logic    out_valid,
   output geo_type out_geo
);

   logic [4:0] vld_ff;

   // stage 0: input word
   logic signed [15:0] px_ff, py_ff;

   // stage A
   logic signed [32:0] a_t1_in, a_t1_ff;
   logic signed [33:0] a_n_in, a_n_ff;
   logic [31:0]        a_den_in, a_den_ff;
   logic signed [47:0] a_ac_in, a_ac_ff;
   logic signed [33:0] a_vl_in, a_vl_ff, a_vh_in, a_vh_ff;
   logic signed [16:0] a_ul_in, a_ul_ff, a_uh_in, a_uh_ff;
   logic [30:0]        a_bb_in, a_bb_ff;
   logic signed [15:0] a_py_ff;
   logic               a_inv_in, a_inv_ff, a_bz_in, a_bz_ff;

   logic signed [31:0] apx, bpy, bpx, apy, aa, bb, axl, axh;
   logic signed [32:0] den_sum;

   always_comb begin
      apx = cfg.coef_a * px_ff;
      bpy = cfg.coef_b * py_ff;
      bpx = cfg.coef_b * px_ff;
      apy = cfg.coef_a * py_ff;
      aa  = cfg.coef_a * cfg.coef_a;
      bb  = cfg.coef_b * cfg.coef_b;
      axl = cfg.coef_a * cfg.seg_x_low;
      axh = cfg.coef_a * cfg.seg_x_high;
      den_sum  = 33'(aa) + 33'(bb);
      a_t1_in  = 33'(bpx) - 33'(apy);
      a_n_in   = 34'(apx) + 34'(bpy) + 34'(cfg.coef_c);
      a_den_in = den_sum[31:0];
      a_ac_in  = cfg.coef_a * cfg.coef_c;
      a_vl_in  = 34'(axl) + 34'(cfg.coef_c) + 34'(bpy);
      a_vh_in  = 34'(axh) + 34'(cfg.coef_c) + 34'(bpy);
      a_ul_in  = 17'(cfg.seg_x_low) - 17'(px_ff);
      a_uh_in  = 17'(cfg.seg_x_high) - 17'(px_ff);
      a_bb_in  = bb[30:0];
      a_inv_in = (cfg.coef_a == 16'sd0) && (cfg.coef_b == 16'sd0);
      a_bz_in  = (cfg.coef_b == 16'sd0);
   end

   // stage B
   logic signed [48:0] b_proj_in, b_proj_ff, b_lo_in, b_lo_ff, b_hi_in, b_hi_ff;
   logic [65:0]        b_n2_in, b_n2_ff;
   logic [65:0]        b_vl2_in, b_vl2_ff, b_vh2_in, b_vh2_ff;
   logic [31:0]        b_ul2_in, b_ul2_ff, b_uh2_in, b_uh2_ff, b_py2_in, b_py2_ff;
   logic [31:0]        b_den_ff;
   logic [30:0]        b_bb_ff;
   logic               b_inv_ff, b_bz_ff;

   logic signed [48:0] bt;
   logic signed [32:0] den_s;
   logic [32:0]        nm, vlm, vhm;
   logic [15:0]        ulm, uhm;
   logic signed [31:0] pysq;

   always_comb begin
      den_s     = $signed({1'b0, a_den_ff});
      bt        = cfg.coef_b * a_t1_ff;
      b_proj_in = bt - 49'(a_ac_ff);
      b_lo_in   = cfg.seg_x_low * den_s;
      b_hi_in   = cfg.seg_x_high * den_s;
      nm  = a_n_ff[33]  ? 33'(-a_n_ff)  : 33'(a_n_ff);
      vlm = a_vl_ff[33] ? 33'(-a_vl_ff) : 33'(a_vl_ff);
      vhm = a_vh_ff[33] ? 33'(-a_vh_ff) : 33'(a_vh_ff);
      ulm = a_ul_ff[16] ? 16'(-a_ul_ff) : 16'(a_ul_ff);
      uhm = a_uh_ff[16] ? 16'(-a_uh_ff) : 16'(a_uh_ff);
      b_n2_in  = 66'(nm) * 66'(nm);
      b_vl2_in = 66'(vlm) * 66'(vlm);
      b_vh2_in = 66'(vhm) * 66'(vhm);
      b_ul2_in = 32'(ulm) * 32'(ulm);
      b_uh2_in = 32'(uhm) * 32'(uhm);
      pysq     = a_py_ff * a_py_ff;
      b_py2_in = $unsigned(pysq);
   end

   // stage C
   logic        c_hit_in, c_hit_ff;
   logic [65:0] c_dl_in, c_dl_ff, c_dh_in, c_dh_ff, c_n2_ff;
   logic [31:0] c_den_ff;
   logic [30:0] c_bb_ff;
   logic        c_inv_ff, c_bz_ff;
   logic [62:0] ulbb, uhbb;

   always_comb begin
      c_hit_in = (b_proj_ff >= b_lo_ff) && (b_proj_ff <= b_hi_ff);
      ulbb = 63'(b_ul2_ff) * 63'(b_bb_ff);
      uhbb = 63'(b_uh2_ff) * 63'(b_bb_ff);
      if (b_bz_ff) begin
         // vertical line: both end points sit at y = 0
         c_dl_in = 66'(b_ul2_ff) + 66'(b_py2_ff);
         c_dh_in = 66'(b_uh2_ff) + 66'(b_py2_ff);
      end else begin
         c_dl_in = 66'(ulbb) + b_vl2_ff;
         c_dh_in = 66'(uhbb) + b_vh2_ff;
      end
   end

   // stage D
   geo_type d_geo_in, d_geo_ff;

   always_comb begin
      d_geo_in.invalid = c_inv_ff;
      if (c_inv_ff) begin
         d_geo_in.sq    = '0;
         d_geo_in.scale = ScaleW'(1);
      end else if (c_hit_ff) begin
         d_geo_in.sq    = c_n2_ff;
         d_geo_in.scale = c_den_ff;
      end else begin
         d_geo_in.sq    = (c_dl_ff < c_dh_ff) ? c_dl_ff : c_dh_ff;
         d_geo_in.scale = c_bz_ff ? ScaleW'(1) : ScaleW'(c_bb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= in_word.point_x;
      py_ff    <= in_word.point_y;
      a_t1_ff  <= a_t1_in;
      a_n_ff   <= a_n_in;
      a_den_ff <= a_den_in;
      a_ac_ff  <= a_ac_in;
      a_vl_ff  <= a_vl_in;
      a_vh_ff  <= a_vh_in;
      a_ul_ff  <= a_ul_in;
      a_uh_ff  <= a_uh_in;
      a_bb_ff  <= a_bb_in;
      a_py_ff  <= py_ff;
      a_inv_ff <= a_inv_in;
      a_bz_ff  <= a_bz_in;
      b_proj_ff <= b_proj_in;
      b_lo_ff   <= b_lo_in;
      b_hi_ff   <= b_hi_in;
      b_n2_ff   <= b_n2_in;
      b_vl2_ff  <= b_vl2_in;
      b_vh2_ff  <= b_vh2_in;
      b_ul2_ff  <= b_ul2_in;
      b_uh2_ff  <= b_uh2_in;
      b_py2_ff  <= b_py2_in;
      b_den_ff  <= a_den_ff;
      b_bb_ff   <= a_bb_ff;
      b_inv_ff  <= a_inv_ff;
      b_bz_ff   <= a_bz_ff;
      c_hit_ff <= c_hit_in;
      c_dl_ff  <= c_dl_in;
      c_dh_ff  <= c_dh_in;
      c_n2_ff  <= b_n2_ff;
      c_den_ff <= b_den_ff;
      c_bb_ff  <= b_bb_ff;
      c_inv_ff <= b_inv_ff;
      c_bz_ff  <= b_bz_ff;
      d_geo_ff <= d_geo_in;
   end

   assign out_valid = vld_ff[4];
   assign out_geo   = d_geo_ff;

endmodule

>>> design/psd_root.sv
// Pipelined integer root: largest q below 2^16 with q*q*scale <= sq.
// One result bit per stage, add and compare only. Depends on psd_pkg.
module psd_root
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  geo_type in_geo,
   output logic    out_valid,
   output rsp_type out_word
);

   localparam int Last = RootBits - 1;

   logic                vld_ff [RootBits];
   logic [RootBits-1:0] q_ff   [RootBits];
   logic                inv_ff [RootBits];
   // carried only between stages
   logic [SumW-1:0]     sq_ff  [Last];
   logic [ScaleW-1:0]   sc_ff  [Last];
   logic [SumW-1:0]     p_ff   [Last];   // q*q*scale
   logic [QsW-1:0]      qs_ff  [Last];   // q*scale

   for (genvar gi = 0; gi < RootBits; gi++) begin : g_stage
      localparam int K = Last - gi;
      logic                v_cur, inv_cur, take;
      logic [SumW-1:0]     sq_cur, p_cur;
      logic [ScaleW-1:0]   sc_cur;
      logic [QsW-1:0]      qs_cur;
      logic [RootBits-1:0] q_cur;
      logic [SumW+1:0]     cand;

      if (gi == 0) begin : g_src
         assign v_cur   = in_valid;
         assign inv_cur = in_geo.invalid;
         assign sq_cur  = in_geo.sq;
         assign sc_cur  = in_geo.scale;
         assign p_cur   = '0;
         assign qs_cur  = '0;
         assign q_cur   = '0;
      end else begin : g_src
         assign v_cur   = vld_ff[gi-1];
         assign inv_cur = inv_ff[gi-1];
         assign sq_cur  = sq_ff[gi-1];
         assign sc_cur  = sc_ff[gi-1];
         assign p_cur   = p_ff[gi-1];
         assign qs_cur  = qs_ff[gi-1];
         assign q_cur   = q_ff[gi-1];
      end

      // (q + 2^K)^2 * s = q*q*s + 2^(K+1) * q*s + 2^(2K) * s
      assign cand = (SumW+2)'(p_cur) + ((SumW+2)'(qs_cur) << (K + 1))
                  + ((SumW+2)'(sc_cur) << (2 * K));
      assign take = cand <= (SumW+2)'(sq_cur);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[gi] <= 1'b0;
         end else begin
            vld_ff[gi] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         inv_ff[gi] <= inv_cur;
         q_ff[gi]   <= take ? (q_cur | (RootBits'(1) << K)) : q_cur;
      end

      if (gi < Last) begin : g_carry
         always_ff @(posedge clock) begin
            sq_ff[gi] <= sq_cur;
            sc_ff[gi] <= sc_cur;
            p_ff[gi]  <= take ? cand[SumW-1:0] : p_cur;
            qs_ff[gi] <= take ? (qs_cur + (QsW'(sc_cur) << K)) : qs_cur;
         end
      end
   end

   assign out_valid         = vld_ff[Last];
   assign out_word.dist_res = q_ff[Last];
   assign out_word.invalid  = inv_ff[Last];

endmodule

>>> design/psd_check.sv
// Port-level checker for point_segment_distance_top, bound to the top.
// Depends on psd_pkg.
module psd_check
   import psd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_word,
   input logic    pready
);

   localparam int Latency = 21;

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_strobe)
      else $error("accepted word gave no result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Latency))
      else $error("result without accepted word");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.invalid) |-> (rsp_word.dist_res == 16'd0))
      else $error("invalid result carries a distance");

   // busy follows reset only; sampled together so the release edge is clean
   a_ready: assert property (@(posedge clock) disable iff (reset)
      pready && (busy == reset))
      else $error("port held off outside reset");

endmodule

bind point_segment_distance_top psd_check u_psd_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word),
   .pready     (pready)
);
